[hw/rtl/lvm_pkg.sv]
`default_nettype none
package lvm_pkg;

  localparam int unsigned VOICES    = 16;
  localparam int unsigned VOICE_W   = 4;
  localparam int unsigned LOOP_MAX  = 4096;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned LIM_SIZE  = 256;
  localparam int unsigned LIM_STEPS = 17;
  localparam int unsigned UNITY_VOL = 32768;
  localparam int unsigned CNT_W     = 4;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_START  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_TARGET = 3'd4,
    REQ_OFFSET = 3'd5,
    REQ_QUERY  = 3'd6,
    REQ_NOP    = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NO_FREE  = 2'd3
  } stat_e;

  typedef enum logic {
    CFG_LOOP_LEN = 1'b0,
    CFG_VOL_STEP = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_SCAN, CS_DRAIN0, CS_DRAIN1, CS_LIM0, CS_LIM1, CS_LIM2, CS_LIM3,
    CS_MOD, CS_EXEC, CS_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic             latch;
    logic             scan;
    logic             lim0;
    logic             lim1;
    logic             lim2;
    logic             lim3;
    logic             modstep;
    logic             exec;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef logic [16:0] lim_tab_t [0:LIM_SIZE];

  typedef int unsigned angle_tab_t [0:LIM_STEPS-1];
  localparam angle_tab_t CORDIC_ANGLE = '{32768, 19344, 10221, 5188, 2604, 1303, 652,
                                          326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

  // atan(x)*2/pi knots, Q16, via integer CORDIC in vectoring mode
  function automatic lim_tab_t build_lim_tab();
    lim_tab_t t;
    longint x, y, z, xs, ys;
    for (int j = 0; j <= LIM_SIZE; j++) begin
      x = 64'sd65536;
      y = (longint'(j) * VOICES * 65536) / LIM_SIZE;
      z = 0;
      for (int i = 0; i < LIM_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + longint'(CORDIC_ANGLE[i]);
        end else if (y < 0) begin
          x = x - ys; y = y + xs; z = z - longint'(CORDIC_ANGLE[i]);
        end
      end
      if (z < 0) z = 0;
      if (z > 65536) z = 65536;
      t[j] = z[16:0];
    end
    return t;
  endfunction

  localparam lim_tab_t LIM_TAB = build_lim_tab();

endpackage
`default_nettype wire

[hw/rtl/lvm_ctrl.sv]
`default_nettype none
module lvm_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  wire logic [2:0]   req_type_i,
  output lvm_pkg::cmd_t     cmd_o,
  output logic              busy,
  output logic              result_valid_o
);
  import lvm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (start) begin
          if (req_e'(req_type_i) == REQ_TICK) state_d = CS_SCAN;
          else if (req_e'(req_type_i) == REQ_OFFSET) state_d = CS_MOD;
          else state_d = CS_EXEC;
        end
      end
      CS_SCAN:   if (cnt_q == CNT_W'(VOICES - 1)) state_d = CS_DRAIN0;
      CS_DRAIN0: state_d = CS_DRAIN1;
      CS_DRAIN1: state_d = CS_LIM0;
      CS_LIM0:   state_d = CS_LIM1;
      CS_LIM1:   state_d = CS_LIM2;
      CS_LIM2:   state_d = CS_LIM3;
      CS_LIM3:   state_d = CS_OUT;
      CS_MOD:    if (cnt_q == CNT_W'(LEN_W - 1)) state_d = CS_EXEC;
      CS_EXEC:   state_d = CS_OUT;
      CS_OUT:    state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == CS_SCAN || state_q == CS_MOD) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.latch   = start && (state_q == CS_IDLE);
    cmd_o.scan    = (state_q == CS_SCAN);
    cmd_o.lim0    = (state_q == CS_LIM0);
    cmd_o.lim1    = (state_q == CS_LIM1);
    cmd_o.lim2    = (state_q == CS_LIM2);
    cmd_o.lim3    = (state_q == CS_LIM3);
    cmd_o.modstep = (state_q == CS_MOD);
    cmd_o.exec    = (state_q == CS_EXEC);
    cmd_o.cnt     = cnt_q;
    busy          = (state_q != CS_IDLE);
    result_valid_o = (state_q == CS_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_out_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_OUT) |=> (state_q == CS_IDLE)) else $error("result strobe held");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat not taken");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_DRAIN0) |-> ($past(cnt_q) == CNT_W'(VOICES - 1)))
    else $error("scan cut short");
endmodule
`default_nettype wire

[hw/rtl/lvm_dp.sv]
`default_nettype none
module lvm_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lvm_pkg::cmd_t cmd_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic [2:0]    req_type_i,
  input  wire logic [3:0]    voice_i,
  input  wire logic [11:0]   slot_index_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic [15:0]   tgt_vol_i,
  output logic signed [15:0] mixed_sample_o,
  output logic [3:0]         assigned_voice_o,
  output logic [11:0]        voice_position_o,
  output logic [11:0]        voice_offset_o,
  output logic [11:0]        loop_position_o,
  output logic [1:0]         status_o
);
  import lvm_pkg::*;

  logic [LEN_W-1:0] loop_len_q;
  logic [15:0]      vol_step_q;
  req_e             req_q;
  logic [VOICE_W-1:0] v_q;
  logic [POS_W-1:0] idx_q;
  logic [15:0]      smp_q, tgtin_q;

  logic [VOICES-1:0] act_q;
  logic [15:0]       vol_q [VOICES];
  logic [15:0]       tgt_q [VOICES];
  logic [POS_W-1:0]  pos_q [VOICES];
  logic [POS_W-1:0]  gpos_q;

  logic [15:0] mem [VOICES*LOOP_MAX];
  logic [15:0] rd_q;

  logic              act1_q, any_q;
  logic [15:0]       vol1_q;
  logic signed [32:0] prod_q;
  logic signed [37:0] acc_q;

  logic        neg_q, up_q;
  logic [16:0] a_q, diff_q;
  logic [25:0] frac_q;
  logic [29:0] ph_q, pl_q;

  logic [LEN_W:0] rem_q;

  logic [15:0] res_mix_q;
  logic [3:0]  res_asg_q;
  logic [11:0] res_pos_q, res_off_q;
  stat_e       res_st_q;

  logic [LEN_W-1:0] len;
  always_comb begin
    if (loop_len_q == '0) len = LEN_W'(1);
    else if (loop_len_q > LEN_W'(LOOP_MAX)) len = LEN_W'(LOOP_MAX);
    else len = loop_len_q;
  end

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p,
                                                input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= l) ? '0 : n[POS_W-1:0];
  endfunction

  // scan-side reads of the voice under the counter
  logic [VOICE_W-1:0] sv;
  logic [15:0] sv_vol, sv_tgt, sv_vnew;
  logic [16:0] vsum;
  assign sv     = cmd_i.cnt;
  assign sv_vol = vol_q[sv];
  assign sv_tgt = tgt_q[sv];
  assign vsum   = {1'b0, sv_vol} + {1'b0, vol_step_q};
  always_comb begin
    if (sv_vol < sv_tgt)
      sv_vnew = ((sv_tgt - sv_vol) <= vol_step_q) ? sv_tgt : vsum[15:0];
    else if (sv_vol > sv_tgt)
      sv_vnew = ((sv_vol - sv_tgt) <= vol_step_q) ? sv_tgt : sv_vol - vol_step_q;
    else
      sv_vnew = sv_vol;
  end

  // lowest free slot
  logic free_found;
  logic [VOICE_W-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_found = 1'b1;
        free_idx   = VOICE_W'(i);
      end
    end
  end

  // offset modulo: one remainder bit per cycle
  logic [LEN_W-1:0] nsum;
  logic [LEN_W:0]   rem_sh;
  assign nsum   = {1'b0, gpos_q} + {1'b0, idx_q};
  assign rem_sh = {(cmd_i.cnt == '0) ? LEN_W'(0) : rem_q[LEN_W-1:0],
                   nsum[CNT_W'(LEN_W - 1) - cmd_i.cnt]};

  // limiter front end
  logic [37:0] mag_full;
  logic [34:0] mag;
  logic [8:0]  k, kn;
  logic [16:0] ta, tb;
  assign mag_full = acc_q[37] ? 38'(-acc_q) : 38'(acc_q);
  assign mag = (mag_full > 38'(35'h4_0000_0000)) ? 35'h4_0000_0000 : mag_full[34:0];
  assign k   = mag[34:26];
  assign kn  = k[8] ? k : k + 1'b1;
  assign ta  = LIM_TAB[k];
  assign tb  = LIM_TAB[kn];

  logic [43:0] tsum;
  logic [16:0] stepv, val;
  logic [31:0] scaled;
  logic [15:0] omag;
  assign tsum   = {ph_q, 13'b0} + 44'(pl_q);
  assign stepv  = tsum[42:26];
  assign val    = up_q ? a_q + stepv : a_q - stepv;
  assign scaled = {val, 15'b0} - 32'(val);
  assign omag   = scaled[31:16];

  logic [POS_W-1:0] vp;
  assign vp = pos_q[v_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_len_q <= LEN_W'(LOOP_MAX);
      vol_step_q <= 16'd74;
      act_q      <= '0;
      gpos_q     <= '0;
      for (int i = 0; i < VOICES; i++) begin
        vol_q[i] <= '0;
        tgt_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_LOOP_LEN: loop_len_q <= cfg_data_i[LEN_W-1:0];
          CFG_VOL_STEP: vol_step_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.scan && act_q[sv]) begin
        vol_q[sv] <= sv_vnew;
        pos_q[sv] <= next_pos(pos_q[sv], len);
      end
      if (cmd_i.lim0) gpos_q <= next_pos(gpos_q, len);
      if (cmd_i.exec) begin
        unique case (req_q)
          REQ_START: if (free_found) begin
            act_q[free_idx] <= 1'b1;
            vol_q[free_idx] <= '0;
            tgt_q[free_idx] <= '0;
            pos_q[free_idx] <= gpos_q;
          end
          REQ_STOP:   if (act_q[v_q]) act_q[v_q] <= 1'b0;
          REQ_TARGET: if (act_q[v_q])
            tgt_q[v_q] <= (tgtin_q > 16'(UNITY_VOL)) ? 16'(UNITY_VOL) : tgtin_q;
          REQ_OFFSET: if (act_q[v_q] && ({1'b0, idx_q} < len))
            pos_q[v_q] <= rem_q[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && req_q == REQ_WRITE) mem[{v_q, idx_q}] <= smp_q;
    rd_q <= mem[{sv, pos_q[sv]}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_e'(req_type_i);
      v_q     <= voice_i;
      idx_q   <= slot_index_i;
      smp_q   <= sample_value_i;
      tgtin_q <= tgt_vol_i;
    end
    act1_q <= cmd_i.scan && act_q[sv];
    vol1_q <= sv_vol;
    prod_q <= act1_q ? $signed(rd_q) * $signed({1'b0, vol1_q}) : 33'sd0;
    if (cmd_i.latch) begin
      acc_q <= '0;
      any_q <= 1'b0;
    end else begin
      acc_q <= acc_q + 38'(prod_q);
      any_q <= any_q | act1_q;
    end
    if (cmd_i.modstep) rem_q <= (rem_sh >= {1'b0, len}) ? rem_sh - {1'b0, len} : rem_sh;
    if (cmd_i.lim0) begin
      neg_q  <= acc_q[37];
      a_q    <= ta;
      up_q   <= (tb >= ta);
      diff_q <= k[8] ? '0 : ((tb >= ta) ? tb - ta : ta - tb);
      frac_q <= mag[25:0];
    end
    if (cmd_i.lim1) ph_q <= diff_q * frac_q[25:13];
    if (cmd_i.lim2) pl_q <= diff_q * frac_q[12:0];
    if (cmd_i.lim3) begin
      res_mix_q <= !any_q ? '0 : (neg_q ? 16'(-omag) : omag);
      res_asg_q <= '0;
      res_pos_q <= '0;
      res_off_q <= '0;
      res_st_q  <= ST_OK;
    end
    if (cmd_i.exec) begin
      res_mix_q <= '0;
      res_asg_q <= '0;
      res_pos_q <= '0;
      res_off_q <= '0;
      res_st_q  <= ST_OK;
      unique case (req_q)
        REQ_START: begin
          if (free_found) res_asg_q <= free_idx;
          else res_st_q <= ST_NO_FREE;
        end
        REQ_STOP, REQ_TARGET: if (!act_q[v_q]) res_st_q <= ST_INACTIVE;
        REQ_OFFSET: begin
          if (!act_q[v_q]) res_st_q <= ST_INACTIVE;
          else if ({1'b0, idx_q} >= len) res_st_q <= ST_RANGE;
        end
        REQ_QUERY: begin
          if (!act_q[v_q]) res_st_q <= ST_INACTIVE;
          else begin
            res_pos_q <= vp;
            res_off_q <= (vp >= gpos_q) ? vp - gpos_q
                                        : POS_W'(len + {1'b0, vp} - {1'b0, gpos_q});
          end
        end
        default: ;
      endcase
    end
  end

  assign mixed_sample_o   = res_mix_q;
  assign assigned_voice_o = res_asg_q;
  assign voice_position_o = res_pos_q;
  assign voice_offset_o   = res_off_q;
  assign loop_position_o  = gpos_q;
  assign status_o         = res_st_q;

  a_gpos_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lim0 |=> (gpos_q == next_pos($past(gpos_q), len))) else $error("loop pos");
  a_lim_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lim0 |=> cmd_i.lim1) else $error("limiter sequence");
  a_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lim0 |-> (!act1_q && prod_q == '0)) else $error("mac not drained");
endmodule
`default_nettype wire

[hw/rtl/looping_voice_mixer_with_ramp.sv]
`default_nettype none
// channel   direction  handshake             payload
// request   in         start & !busy         req_type, voice, slot_index, sample_value,
//                                            tgt_vol
// result    out        result_valid_o pulse  mixed_sample, assigned_voice, voice_position,
//                                            voice_offset, loop_position, status
// config    in         cfg_valid_i & ready   cfg_index_i, cfg_data_i
//
// Tick: voice scan over every voice on one shared MAC, then 2 drain states, 4 limiter
// steps and the out state that raises the strobe. Set offset: 13-step remainder unit,
// exec, out. Other requests: exec, out.
// One request at a time; busy stays high through the strobe cycle, so the next beat
// is taken in the cycle after it. Reset clears control and voice state; sample memory
// is not cleared. The result beat lasts one cycle and cannot be stalled.
module looping_voice_mixer_with_ramp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [2:0]   req_type_i,
  input  wire logic [3:0]   voice_i,
  input  wire logic [11:0]  slot_index_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic [15:0]  tgt_vol_i,
  output logic              result_valid_o,
  output logic signed [15:0] mixed_sample_o,
  output logic [3:0]        assigned_voice_o,
  output logic [11:0]       voice_position_o,
  output logic [11:0]       voice_offset_o,
  output logic [11:0]       loop_position_o,
  output logic [1:0]        status_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);
  import lvm_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lvm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .req_type_i,
    .cmd_o(cmd), .busy, .result_valid_o
  );

  lvm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .req_type_i, .voice_i, .slot_index_i, .sample_value_i, .tgt_vol_i,
    .mixed_sample_o, .assigned_voice_o, .voice_position_o, .voice_offset_o,
    .loop_position_o, .status_o
  );
endmodule
`default_nettype wire

[verif/tb_looping_voice_mixer_with_ramp.sv]
`default_nettype none
module tb_looping_voice_mixer_with_ramp;
  timeunit 1ns;
  timeprecision 1ps;
  import lvm_pkg::*;

  typedef struct packed {
    logic signed [15:0] mix;
    logic [3:0]         av;
    logic [11:0]        vpos;
    logic [11:0]        voff;
    logic [11:0]        lpos;
    logic [1:0]         st;
  } mix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] req_type_i = REQ_NOP;
  logic [3:0] voice_i = '0;
  logic [11:0] slot_index_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic [15:0] tgt_vol_i = '0;
  logic result_valid_o;
  logic signed [15:0] mixed_sample_o;
  logic [3:0] assigned_voice_o;
  logic [11:0] voice_position_o, voice_offset_o, loop_position_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CFG_LOOP_LEN;
  logic [15:0] cfg_data_i = '0;

  looping_voice_mixer_with_ramp dut (.*);

  // mirror of the mixer state
  shortint     samples [0:VOICES*LOOP_MAX-1];
  bit          written [0:VOICES*LOOP_MAX-1];
  bit          active [0:VOICES-1];
  int unsigned vol [0:VOICES-1];
  int unsigned tgt [0:VOICES-1];
  int unsigned vpos [0:VOICES-1];
  int unsigned gpos;
  int unsigned loop_len_reg;
  int unsigned step_reg;
  longint      atan_knot [0:LIM_SIZE];
  mix_res_t    pending_mix [$];
  int          errs = 0;
  bit          idle_on = 1'b1;

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void build_knots();
    longint x, y, z, xs, ys;
    int unsigned ang [0:16];
    ang = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    for (int j = 0; j <= LIM_SIZE; j++) begin
      x = 65536;
      y = (longint'(j) * VOICES * 65536) / LIM_SIZE;
      z = 0;
      for (int i = 0; i < 17; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ang[i];
        end else if (y < 0) begin
          x -= ys; y += xs; z -= ang[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 65536) z = 65536;
      atan_knot[j] = z;
    end
  endfunction

  function automatic int unsigned eff_len();
    if (loop_len_reg == 0) return 1;
    if (loop_len_reg > LOOP_MAX) return LOOP_MAX;
    return loop_len_reg;
  endfunction

  function automatic int unsigned wrap_next(int unsigned p, int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic longint limit_mix(longint acc);
    longint mag, den, num, k, fr, a, b, val, outv;
    den = longint'(VOICES) << 30;
    mag = acc < 0 ? -acc : acc;
    if (mag > den) mag = den;
    num = mag * LIM_SIZE;
    k = num / den;
    fr = num % den;
    if (k >= LIM_SIZE) val = atan_knot[LIM_SIZE];
    else begin
      a = atan_knot[k];
      b = atan_knot[k+1];
      val = (b >= a) ? a + ((b - a) * fr) / den : a - ((a - b) * fr) / den;
    end
    outv = (val * 32767) >>> 16;
    return acc < 0 ? -outv : outv;
  endfunction

  function automatic mix_res_t predict_mix(req_e r, int unsigned v, int unsigned idx,
                                           logic [15:0] sv, int unsigned tv);
    mix_res_t res;
    int unsigned len, p, vl, t, q;
    longint acc;
    bit any;
    len = eff_len();
    res = '0;
    res.st = ST_OK;
    case (r)
      REQ_TICK: begin
        acc = 0;
        any = 0;
        for (int i = 0; i < VOICES; i++) begin
          if (!active[i]) continue;
          any = 1;
          vl = vol[i];
          t = tgt[i];
          p = vpos[i] % LOOP_MAX;
          acc += longint'(samples[i*LOOP_MAX + p]) * longint'(vl);
          if (vl < t) vl = (t - vl <= step_reg) ? t : vl + step_reg;
          else if (vl > t) vl = (vl - t <= step_reg) ? t : vl - step_reg;
          vol[i] = vl;
          vpos[i] = wrap_next(p, len);
        end
        if (any) res.mix = 16'(limit_mix(acc));
        gpos = wrap_next(gpos, len);
      end
      REQ_WRITE: begin
        samples[v*LOOP_MAX + idx] = shortint'(sv);
        written[v*LOOP_MAX + idx] = 1'b1;
      end
      REQ_START: begin
        q = VOICES;
        for (int i = VOICES - 1; i >= 0; i--) if (!active[i]) q = i;
        if (q == VOICES) res.st = ST_NO_FREE;
        else begin
          active[q] = 1'b1;
          vol[q] = 0;
          tgt[q] = 0;
          vpos[q] = gpos;
          res.av = 4'(q);
        end
      end
      REQ_STOP: if (!active[v]) res.st = ST_INACTIVE; else active[v] = 1'b0;
      REQ_TARGET: begin
        if (!active[v]) res.st = ST_INACTIVE;
        else tgt[v] = tv > UNITY_VOL ? UNITY_VOL : tv;
      end
      REQ_OFFSET: begin
        if (!active[v]) res.st = ST_INACTIVE;
        else if (idx >= len) res.st = ST_RANGE;
        else vpos[v] = (gpos + idx) % len;
      end
      REQ_QUERY: begin
        if (!active[v]) res.st = ST_INACTIVE;
        else begin
          p = vpos[v];
          res.vpos = 12'(p);
          res.voff = 12'((p >= gpos) ? p - gpos : len + p - gpos);
        end
      end
      default: ;
    endcase
    res.lpos = 12'(gpos);
    return res;
  endfunction

  always @(posedge clk_i) begin
    mix_res_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_mix.size() == 0) begin
        errs++;
        $error("result beat with nothing expected");
      end else begin
        e = pending_mix.pop_front();
        if (mixed_sample_o !== e.mix) begin
          errs++;
          $error("mixed_sample exp %0d got %0d", e.mix, mixed_sample_o);
        end
        if (assigned_voice_o !== e.av) begin
          errs++;
          $error("assigned_voice exp %0d got %0d", e.av, assigned_voice_o);
        end
        if (voice_position_o !== e.vpos) begin
          errs++;
          $error("voice_position exp %0d got %0d", e.vpos, voice_position_o);
        end
        if (voice_offset_o !== e.voff) begin
          errs++;
          $error("voice_offset exp %0d got %0d", e.voff, voice_offset_o);
        end
        if (loop_position_o !== e.lpos) begin
          errs++;
          $error("loop_position exp %0d got %0d", e.lpos, loop_position_o);
        end
        if (status_o !== e.st) begin
          errs++;
          $error("status exp %0d got %0d", e.st, status_o);
        end
      end
    end
  end

  // one request beat; returns at the accepting edge with start still high
  task automatic send_req(req_e r, logic [3:0] v, logic [11:0] idx, logic [15:0] sv,
                          logic [15:0] tv);
    @(posedge clk_i);
    start <= 1'b1;
    req_type_i <= r;
    voice_i <= v;
    slot_index_i <= idx;
    sample_value_i <= sv;
    tgt_vol_i <= tv;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_mix.push_back(predict_mix(r, v, idx, sv, tv));
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(99) < 30) begin
      @(posedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(6)) @(posedge clk_i);
    end
  endtask

  // fills any sample the next tick would read but was never written
  task automatic send_tick();
    for (int i = 0; i < VOICES; i++)
      if (active[i] && !written[i*LOOP_MAX + vpos[i] % LOOP_MAX])
        send_req(REQ_WRITE, 4'(i), 12'(vpos[i] % LOOP_MAX), 16'($urandom), '0);
    send_req(REQ_TICK, 4'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    start <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LOOP_LEN) loop_len_reg = data & 16'h1FFF;
    else step_reg = data;
  endtask

  task automatic set_config(logic [15:0] len, logic [15:0] stp);
    wait_drained();
    write_reg(CFG_LOOP_LEN, len);
    write_reg(CFG_VOL_STEP, stp);
  endtask

  function automatic logic [3:0] pick_voice();
    int unsigned v;
    v = $urandom_range(VOICES - 1);
    if ($urandom_range(9) < 8)
      for (int i = 0; i < VOICES; i++) if (active[(v + i) % VOICES]) return 4'((v + i) % VOICES);
    return 4'(v);
  endfunction

  task automatic test_directed();
    send_req(REQ_NOP, 4'hF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_STOP, 4'd3, '0, '0, '0);
    send_req(REQ_TARGET, 4'd15, '0, '0, 16'd1000);
    send_req(REQ_OFFSET, 4'd0, 12'd1, '0, '0);
    send_req(REQ_QUERY, 4'd7, '0, '0, '0);
    send_tick();
    send_req(REQ_START, '0, '0, '0, '0);
    send_req(REQ_START, '0, '0, '0, '0);
    send_req(REQ_TARGET, 4'd0, '0, '0, 16'hFFFF);
    send_req(REQ_TARGET, 4'd1, '0, '0, 16'd32768);
    send_req(REQ_WRITE, 4'd0, 12'd4095, 16'h8000, '0);
    send_req(REQ_OFFSET, 4'd0, 12'd4095, '0, '0);
    send_req(REQ_WRITE, 4'd15, 12'd0, 16'h7FFF, '0);
    send_tick();
    send_tick();
    send_req(REQ_QUERY, 4'd0, '0, '0, '0);
    send_req(REQ_QUERY, 4'd1, '0, '0, '0);
    send_req(REQ_STOP, 4'd0, '0, '0, '0);
    send_tick();
  endtask

  // every slot started plus one start too many, then all at unity on full-scale samples
  task automatic test_full_scale();
    set_config(16'd2, 16'd32768);
    for (int i = 0; i < VOICES; i++) send_req(REQ_START, '0, '0, '0, '0);
    send_req(REQ_START, '0, '0, '0, '0);
    for (int i = 0; i < VOICES; i++) begin
      send_req(REQ_TARGET, 4'(i), '0, '0, 16'd32768);
      send_req(REQ_WRITE, 4'(i), 12'd0, 16'h8000, '0);
      send_req(REQ_WRITE, 4'(i), 12'd1, 16'h8000, '0);
    end
    repeat (3) send_tick();
    for (int i = 0; i < VOICES; i++) send_req(REQ_WRITE, 4'(i), 12'd0, 16'h7FFF, '0);
    repeat (3) send_tick();
    send_req(REQ_OFFSET, 4'd5, 12'd2, '0, '0);
    for (int i = 0; i < VOICES; i++) send_req(REQ_STOP, 4'(i), '0, '0, '0);
  endtask

  task automatic test_random(int n);
    int unsigned k;
    logic [3:0] v;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      v = pick_voice();
      if (k < 40) send_tick();
      else if (k < 55) begin
        if (active[v] && $urandom_range(1))
          send_req(REQ_WRITE, v, 12'(vpos[v] % LOOP_MAX), 16'($urandom), '0);
        else send_req(REQ_WRITE, 4'($urandom), 12'($urandom), 16'($urandom), '0);
      end
      else if (k < 65) send_req(REQ_START, 4'($urandom), 12'($urandom), '0, '0);
      else if (k < 71) send_req(REQ_STOP, v, '0, '0, '0);
      else if (k < 81) send_req(REQ_TARGET, v, '0, '0,
                                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32768)));
      else if (k < 88) send_req(REQ_OFFSET, v,
                                $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(eff_len())),
                                '0, '0);
      else if (k < 96) send_req(REQ_QUERY, v, '0, '0, '0);
      else send_req(REQ_NOP, 4'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
      maybe_idle();
    end
  endtask

  initial begin
    build_knots();
    loop_len_reg = 4096;
    step_reg = 74;
    gpos = 0;
    for (int i = 0; i < VOICES; i++) begin
      active[i] = 0; vol[i] = 0; tgt[i] = 0; vpos[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_scale();
    set_config(16'd8, 16'd1000);
    test_random(120);
    set_config(16'd1, 16'd0);
    test_random(50);
    set_config(16'h1FFF, 16'd32768);
    test_random(20);
    set_config(16'd0, 16'hFFFF);
    test_random(40);
    set_config(16'd5, 16'd74);
    idle_on = 1'b0;
    test_random(100);
    idle_on = 1'b1;
    set_config(16'($urandom_range(3, 40)), 16'($urandom));
    test_random(90);
    wait_drained();
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hw/rtl/lvm_pkg.sv
hw/rtl/lvm_ctrl.sv
hw/rtl/lvm_dp.sv
hw/rtl/looping_voice_mixer_with_ramp.sv
verif/tb_looping_voice_mixer_with_ramp.sv
